// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sharpen window RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsw_pkg.sv =====
// Types and constants shared by the RGB sharpen window modules.
`timescale 1ns / 1ps
`default_nettype none

package rsw_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int WINDOW_RADIUS = 1;
    localparam int WIN_DIM       = 2 * WINDOW_RADIUS + 1;
    localparam int WIN_SPAN      = WIN_DIM - 1;
    localparam int MIN_WIDTH     = 3;

    localparam int NUM_CH   = 3;
    localparam int CH_W     = 8;
    localparam int PIX_MAX  = 255;
    localparam int WEIGHT_W = 8;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = 11;
    localparam int ROW_MAX   = 2047;
    localparam int OUT_POS_W = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // arithmetic widths
    localparam int SUM_W    = $clog2(WIN_DIM * PIX_MAX + 1);
    localparam int NSUM_W   = $clog2(WIN_DIM * WIN_DIM * PIX_MAX + 1);
    localparam int PROD_C_W = CH_W + 1 + WEIGHT_W;
    localparam int PROD_E_W = NSUM_W + 1 + WEIGHT_W;
    localparam int TOTAL_W  = PROD_E_W + 1;

    // valid/position stages from the window shift to the result queue push:
    // one window stage plus the three register stages of a channel
    localparam int PIPE_DEPTH = 4;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WEIGHT   = 2'd2;

    localparam logic signed [WEIGHT_W-1:0] CENTER_WEIGHT_RST = 8'sd9;
    localparam logic signed [WEIGHT_W-1:0] EDGE_WEIGHT_RST   = -8'sd1;

    // channel 0 is red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] rgb_sum_t;

    typedef struct packed {
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } out_pos_t;

    typedef struct packed {
        pixel_t   pix;
        out_pos_t pos;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rsw_cell.sv =====
// One window tap: holds a pixel, shifts it on, and adds it into the row's running sums.
`timescale 1ns / 1ps
`default_nettype none

module rsw_cell
    import rsw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift,
    input  pixel_t   pix_in,
    input  rgb_sum_t sum_in,
    output pixel_t   pix_out,
    output rgb_sum_t sum_out
);

    pixel_t pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (shift)
        begin
            pix_reg <= pix_in;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_out[ch] = sum_in[ch] + {{(SUM_W - CH_W){1'b0}}, pix_reg[ch]};
        end
    end

    assign pix_out = pix_reg;

endmodule

`default_nettype wire

// ===== rtl/rsw_line_buf.sv =====
// Two line stores: returns the current pixel and the same column of the two rows above.
`timescale 1ns / 1ps
`default_nettype none

module rsw_line_buf
    import rsw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [COL_W-1:0] addr,
    input  pixel_t           pix,
    output logic             rd_valid,
    output pixel_t           cur,
    output pixel_t           above,
    output pixel_t           above2
);

    pixel_t store_a [MAX_WIDTH];
    pixel_t store_b [MAX_WIDTH];

    logic             valid_reg;
    logic             hit_reg;
    logic [COL_W-1:0] addr_reg;
    pixel_t           pix_reg;
    pixel_t           fwd_reg;
    pixel_t           a_rd_reg;
    pixel_t           b_rd_reg;

    // store_a takes the new pixel at once; store_b takes the old row-above value
    // in the following cycle, once its read data is back
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_rd_reg      <= store_a[addr];
            store_a[addr] <= pix;
            b_rd_reg      <= store_b[addr];
        end
        if (valid_reg)
        begin
            store_b[addr_reg] <= a_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= wr_en;
            if (wr_en)
            begin
                hit_reg <= valid_reg && (addr == addr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_reg <= addr;
            pix_reg  <= pix;
            fwd_reg  <= a_rd_reg;
        end
    end

    // same column back to back (repeated frame start): store_b write still in flight
    assign above2   = hit_reg ? fwd_reg : b_rd_reg;
    assign above    = a_rd_reg;
    assign cur      = pix_reg;
    assign rd_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/rsw_channel.sv =====
// Weighted sum and clamp for one color channel, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module rsw_channel
    import rsw_pkg::*;
(
    input  logic                              clk,
    input  logic [WIN_DIM-1:0][SUM_W-1:0]     row_sum,
    input  logic [CH_W-1:0]                   center,
    input  logic signed [WEIGHT_W-1:0]        center_weight,
    input  logic signed [WEIGHT_W-1:0]        edge_weight,
    output logic [CH_W-1:0]                   level
);

    logic [WIN_DIM-1:0][SUM_W-1:0] rows_reg;
    logic [CH_W-1:0]               center_a_reg;
    logic [NSUM_W-1:0]             nsum_reg;
    logic [NSUM_W-1:0]             nsum_next;
    logic [CH_W-1:0]               center_b_reg;
    logic signed [PROD_C_W-1:0]    prod_c_reg;
    logic signed [PROD_E_W-1:0]    prod_e_reg;
    logic signed [PROD_C_W-1:0]    prod_c_next;
    logic signed [PROD_E_W-1:0]    prod_e_next;
    logic signed [TOTAL_W-1:0]     total;

    // neighbor sum is the full window minus the center
    always_comb
    begin
        nsum_next = '0;
        for (int r = 0; r < WIN_DIM; r++)
        begin
            nsum_next = nsum_next + {{(NSUM_W - SUM_W){1'b0}}, rows_reg[r]};
        end
        nsum_next = nsum_next - {{(NSUM_W - CH_W){1'b0}}, center_a_reg};
    end

    always_comb
    begin
        prod_c_next = $signed({1'b0, center_b_reg}) * center_weight;
        prod_e_next = $signed({1'b0, nsum_reg}) * edge_weight;
    end

    always_ff @(posedge clk)
    begin
        rows_reg     <= row_sum;
        center_a_reg <= center;
        nsum_reg     <= nsum_next;
        center_b_reg <= center_a_reg;
        prod_c_reg   <= prod_c_next;
        prod_e_reg   <= prod_e_next;
    end

    always_comb
    begin
        total = {{(TOTAL_W - PROD_C_W){prod_c_reg[PROD_C_W-1]}}, prod_c_reg}
              + {{(TOTAL_W - PROD_E_W){prod_e_reg[PROD_E_W-1]}}, prod_e_reg};
        priority if (total < 0)
        begin
            level = '0;
        end
        else if (total > $signed(TOTAL_W'(PIX_MAX)))
        begin
            level = CH_W'(PIX_MAX);
        end
        else
        begin
            level = total[CH_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsw_out_fifo.sv =====
// Small result queue between the filter pipeline and the output channel.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsw_out_fifo
    import rsw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output out_item_t head
);

    out_item_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]      count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0]      count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    `ASSERT_ALWAYS(a_fifo_count_range, count_reg <= OCC_W'(FIFO_DEPTH), "fifo count past depth")
    `ASSERT_IMPLIES(a_fifo_no_overflow, push, (count_reg < OCC_W'(FIFO_DEPTH)) || pop, "push into full fifo")
    `ASSERT_IMPLIES(a_fifo_no_underflow, pop, count_reg != '0, "pop from empty fifo")

endmodule

`default_nettype wire

// ===== rtl/rgb_sharpen_3x3_window.sv =====
// Top level of the streaming 3x3 RGB sharpen filter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Streaming 3x3 sharpen on a border-padded RGB image sent in row-major order, one pixel
// per input transaction. Each position with a full window (padded row and column both at
// least 2) yields one output transaction with each channel equal to
// center_weight * center + edge_weight * (sum of the eight neighbors), clamped to 0..255,
// tagged with its row and column in the unpadded image. padded_width is clamped to
// 3..1024 when written. Throughput is one pixel per clock while in_ready is high: the two
// line stores are read and written once per pixel, the window is a 3x3 chain of shift
// cells, and each channel runs through its own multiply/clamp pipeline. out_valid rises
// once a result has passed the line stores, window cells and channel pipeline into the
// result queue. The 8-entry result queue is credit-managed, so input ready drops only when
// 8 transactions are in flight or waiting to be taken.
// Configuration writes are always ready and take effect at once; write only while idle.
module rgb_sharpen_3x3_window
    import rsw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  frame_start,
    input  logic [CH_W-1:0]       red_in,
    input  logic [CH_W-1:0]       green_in,
    input  logic [CH_W-1:0]       blue_in,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       red_out,
    output logic [CH_W-1:0]       green_out,
    output logic [CH_W-1:0]       blue_out,
    output logic [OUT_POS_W-1:0]  out_row,
    output logic [OUT_POS_W-1:0]  out_col
);

    // configuration
    logic [WIDTH_W-1:0]         width_reg;
    logic signed [WEIGHT_W-1:0] center_weight_reg;
    logic signed [WEIGHT_W-1:0] edge_weight_reg;
    logic [WIDTH_W-1:0]         width_wr;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] row_base;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [WIDTH_W-1:0] col_plus;
    logic             wrap_in;
    logic             wrap_out;
    logic             emit;
    out_pos_t         cur_pos;

    logic             in_fire;
    logic             out_fire;
    pixel_t           in_pix;

    // stage after the line-store read
    logic             s1_emit_reg;
    out_pos_t         s1_pos_reg;
    logic             lb_valid;
    pixel_t           lb_cur;
    pixel_t           lb_above;
    pixel_t           lb_above2;

    // window and arithmetic pipeline bookkeeping
    logic [PIPE_DEPTH-1:0] vld_pipe_reg;
    out_pos_t              pos_pipe_reg [PIPE_DEPTH];
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic                  drop;

    pixel_t   row_src [WIN_DIM];
    pixel_t   win_pix [WIN_DIM][WIN_DIM];
    rgb_sum_t win_sum [WIN_DIM][WIN_DIM];
    pixel_t   filt_pix;

    out_item_t fifo_in;
    out_item_t fifo_head;

    assign in_pix    = {blue_in, green_in, red_in};
    assign in_ready  = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_comb
    begin
        width_wr = WIDTH_W'(cfg_data);
        priority if (width_wr < WIDTH_W'(MIN_WIDTH))
        begin
            width_wr = WIDTH_W'(MIN_WIDTH);
        end
        else if (width_wr > WIDTH_W'(MAX_WIDTH))
        begin
            width_wr = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_wr = WIDTH_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg         <= WIDTH_W'(MAX_WIDTH);
            center_weight_reg <= CENTER_WEIGHT_RST;
            edge_weight_reg   <= EDGE_WEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PADDED_WIDTH:  width_reg         <= width_wr;
                CFG_CENTER_WEIGHT: center_weight_reg <= $signed(cfg_data[WEIGHT_W-1:0]);
                CFG_EDGE_WEIGHT:   edge_weight_reg   <= $signed(cfg_data[WEIGHT_W-1:0]);
                default:           ;
            endcase
        end
    end

    // column/row of the incoming pixel; a width shrink mid-row ends the row first
    always_comb
    begin
        col_base = frame_start ? '0 : col_reg;
        row_base = frame_start ? '0 : row_reg;
        wrap_in  = ({1'b0, col_base} >= width_reg);
        if (wrap_in)
        begin
            cur_col = '0;
            cur_row = (row_base == ROW_W'(ROW_MAX)) ? row_base : row_base + 1'b1;
        end
        else
        begin
            cur_col = col_base;
            cur_row = row_base;
        end

        col_plus = {1'b0, cur_col} + 1'b1;
        wrap_out = (col_plus >= width_reg);
        if (wrap_out)
        begin
            col_next = '0;
            row_next = (cur_row == ROW_W'(ROW_MAX)) ? cur_row : cur_row + 1'b1;
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
            row_next = cur_row;
        end

        emit        = (cur_row >= ROW_W'(WIN_SPAN)) && (cur_col >= COL_W'(WIN_SPAN));
        cur_pos.row = OUT_POS_W'(cur_row - ROW_W'(WIN_SPAN));
        cur_pos.col = OUT_POS_W'(cur_col - COL_W'(WIN_SPAN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            s1_emit_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            s1_emit_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pos_reg <= cur_pos;
        end
    end

    rsw_line_buf u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire),
        .addr     (cur_col),
        .pix      (in_pix),
        .rd_valid (lb_valid),
        .cur      (lb_cur),
        .above    (lb_above),
        .above2   (lb_above2)
    );

    // window rows: top row is the oldest, right column the newest
    assign row_src[0] = lb_above2;
    assign row_src[1] = lb_above;
    assign row_src[2] = lb_cur;

    genvar gr, gc, gch;
    generate
        for (gr = 0; gr < WIN_DIM; gr++)
        begin : g_row
            for (gc = 0; gc < WIN_DIM; gc++)
            begin : g_col
                pixel_t   cell_in;
                rgb_sum_t cell_sum_in;
                if (gc == WIN_DIM - 1)
                begin : g_head
                    assign cell_in = row_src[gr];
                end
                else
                begin : g_link
                    assign cell_in = win_pix[gr][gc+1];
                end
                if (gc == 0)
                begin : g_first
                    assign cell_sum_in = '0;
                end
                else
                begin : g_acc
                    assign cell_sum_in = win_sum[gr][gc-1];
                end
                rsw_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (lb_valid),
                    .pix_in  (cell_in),
                    .sum_in  (cell_sum_in),
                    .pix_out (win_pix[gr][gc]),
                    .sum_out (win_sum[gr][gc])
                );
            end
        end

        for (gch = 0; gch < NUM_CH; gch++)
        begin : g_ch
            logic [WIN_DIM-1:0][SUM_W-1:0] rows;
            for (gr = 0; gr < WIN_DIM; gr++)
            begin : g_rs
                assign rows[gr] = win_sum[gr][WIN_DIM-1][gch];
            end
            rsw_channel u_channel (
                .clk           (clk),
                .row_sum       (rows),
                .center        (win_pix[WINDOW_RADIUS][WINDOW_RADIUS][gch]),
                .center_weight (center_weight_reg),
                .edge_weight   (edge_weight_reg),
                .level         (filt_pix[gch])
            );
        end
    endgenerate

    // valid/position pipe tracks the channel pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[PIPE_DEPTH-2:0], lb_valid && s1_emit_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        pos_pipe_reg[0] <= s1_pos_reg;
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            pos_pipe_reg[k] <= pos_pipe_reg[k-1];
        end
    end

    // credits: every accepted pixel holds one until it is dropped or delivered
    assign drop     = lb_valid && !s1_emit_reg;
    assign occ_next = occ_reg + OCC_W'(in_fire) - OCC_W'(drop) - OCC_W'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign fifo_in.pix = filt_pix;
    assign fifo_in.pos = pos_pipe_reg[PIPE_DEPTH-1];

    rsw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_pipe_reg[PIPE_DEPTH-1]),
        .push_item (fifo_in),
        .pop       (out_fire),
        .not_empty (out_valid),
        .head      (fifo_head)
    );

    assign red_out   = fifo_head.pix[0];
    assign green_out = fifo_head.pix[1];
    assign blue_out  = fifo_head.pix[2];
    assign out_row   = fifo_head.pos.row;
    assign out_col   = fifo_head.pos.col;

    `ASSERT_ALWAYS(a_occ_range, occ_reg <= OCC_W'(FIFO_DEPTH), "credit count past queue depth")
    `ASSERT_IMPLIES(a_out_has_credit, out_valid, occ_reg != '0, "result with no credit held")
    `ASSERT_NEXT(a_frame_start_pos, in_fire && frame_start, (row_reg == '0) && (col_reg == COL_W'(1)), "frame start did not restart position")

endmodule

`default_nettype wire

// ===== tb/tb_rgb_sharpen_3x3_window.sv =====
// Self-checking testbench for the streaming 3x3 RGB sharpen window filter.
`timescale 1ns / 1ps

module tb_rgb_sharpen_3x3_window;
    import rsw_pkg::*;

    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PIXELS = 850;
    localparam int PAD_W         = CFG_DATA_W - WEIGHT_W;

    typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER} pattern_t;

    typedef struct {
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } filt_pix_t;

    class sharpen_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        int                    center_w;
        int                    edge_w;
        pixel_t                line_a [MAX_WIDTH];
        pixel_t                line_b [MAX_WIDTH];
        int unsigned           wr_cnt [MAX_WIDTH];
        pixel_t                win [9];
        int unsigned           col_cnt;
        int unsigned           row_cnt;
        filt_pix_t             expected_q [$];
        int                    errors;
        int                    matched;
        int                    taken;

        function new();
            width_reg = CFG_DATA_W'(MAX_WIDTH);
            center_w  = int'(CENTER_WEIGHT_RST);
            edge_w    = int'(EDGE_WEIGHT_RST);
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                line_a[i] = '0;
                line_b[i] = '0;
                wr_cnt[i] = 0;
            end
            for (int k = 0; k < 9; k++)
                win[k] = '0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
            matched = 0;
            taken   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PADDED_WIDTH:  width_reg = data;
                CFG_CENTER_WEIGHT: center_w = int'($signed(data[WEIGHT_W-1:0]));
                CFG_EDGE_WEIGHT:   edge_w = int'($signed(data[WEIGHT_W-1:0]));
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < MIN_WIDTH)
                w = MIN_WIDTH;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;
            return w;
        endfunction

        // both line stores hold real data in every column below w
        function bit cols_ready(int unsigned w);
            for (int i = 0; i < w; i++)
            begin
                if (wr_cnt[i] < 2)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [CH_W-1:0] filter_channel(int ch);
            int ctr;
            int nsum;
            int total;
            ctr  = 0;
            nsum = 0;
            for (int k = 0; k < 9; k++)
            begin
                if (k == 4)
                    ctr = int'(win[k][ch]);
                else
                    nsum += int'(win[k][ch]);
            end
            total = ctr * center_w + nsum * edge_w;
            if (total > PIX_MAX)
                total = PIX_MAX;
            if (total < 0)
                total = 0;
            return CH_W'(total);
        endfunction

        function void next_row();
            col_cnt = 0;
            if (row_cnt < ROW_MAX)
                row_cnt++;
        endfunction

        function void take_pixel(logic fs, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                 logic [CH_W-1:0] b);
            int unsigned w;
            int unsigned c;
            int unsigned rw;
            pixel_t      pix;
            pixel_t      above;
            pixel_t      above2;
            filt_pix_t   e;
            w = eff_width();
            pix = {b, g, r};
            taken++;
            if (fs)
            begin
                col_cnt = 0;
                row_cnt = 0;
            end
            // a shrunk width can leave the column past the row end
            if (col_cnt >= w)
                next_row();
            c  = col_cnt;
            rw = row_cnt;
            above     = line_a[c];
            above2    = line_b[c];
            line_b[c] = above;
            line_a[c] = pix;
            if (wr_cnt[c] < 2)
                wr_cnt[c]++;
            for (int i = 0; i < 3; i++)
            begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = above2;
            win[5] = above;
            win[8] = pix;
            if (rw >= WIN_SPAN && c >= WIN_SPAN)
            begin
                e.red   = filter_channel(0);
                e.green = filter_channel(1);
                e.blue  = filter_channel(2);
                e.row   = OUT_POS_W'(rw - WIN_SPAN);
                e.col   = OUT_POS_W'(c - WIN_SPAN);
                expected_q.push_back(e);
            end
            col_cnt = c + 1;
            if (col_cnt >= w)
                next_row();
        endfunction

        function void check_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                                  logic [OUT_POS_W-1:0] row, logic [OUT_POS_W-1:0] col);
            filt_pix_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output rgb %0d/%0d/%0d at row %0d col %0d",
                             $realtime, r, g, b, row, col);
                return;
            end
            e = expected_q.pop_front();
            if (e.red !== r || e.green !== g || e.blue !== b || e.row !== row || e.col !== col)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp rgb %0d/%0d/%0d @(%0d,%0d) got %0d/%0d/%0d @(%0d,%0d)",
                             $realtime, e.red, e.green, e.blue, e.row, e.col,
                             r, g, b, row, col);
            end
            else
                matched++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PADDED_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  frame_start = 1'b0;
    logic [CH_W-1:0]       red_in = '0;
    logic [CH_W-1:0]       green_in = '0;
    logic [CH_W-1:0]       blue_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CH_W-1:0]       red_out;
    logic [CH_W-1:0]       green_out;
    logic [CH_W-1:0]       blue_out;
    logic [OUT_POS_W-1:0]  out_row;
    logic [OUT_POS_W-1:0]  out_col;

    sharpen_scoreboard sb;
    bit                idle_on = 1'b1;
    int                n_settings = 0;

    rgb_sharpen_3x3_window u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_start(frame_start),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .out_row    (out_row),
        .out_col    (out_col)
    );

    always #5 clk = ~clk;

    // every transaction is seen here on the edge that completes it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.take_pixel(frame_start, red_in, green_in, blue_in);
            if (out_valid && out_ready)
                sb.check_pixel(red_out, green_out, blue_out, out_row, out_col);
        end
    end

    initial
    begin
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic send_pixel(input logic fs, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        frame_start <= fs;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] pick_level();
        logic [CH_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = CH_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic int pick_weight(input bit is_center);
        int k;
        int v;
        k = $urandom_range(0, 9);
        if (k < 4)
            v = is_center ? int'($urandom_range(1, 16)) : -int'($urandom_range(0, 2));
        else if (k < 7)
        begin
            case ($urandom_range(0, 4))
                0:       v = -128;
                1:       v = 127;
                2:       v = 0;
                3:       v = 1;
                default: v = -1;
            endcase
        end
        else
            v = int'($urandom_range(0, 255)) - 128;
        return v;
    endfunction

    task automatic send_frame(input int unsigned w, input int n_items, input pattern_t pat,
                              input bit with_start, input int noise_pct);
        logic            fs;
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        for (int i = 0; i < n_items; i++)
        begin
            fs = (with_start && i == 0) ||
                 (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct);
            case (pat)
                PAT_WHITE:
                begin
                    r = '1; g = '1; b = '1;
                end
                PAT_BLACK:
                begin
                    r = '0; g = '0; b = '0;
                end
                PAT_CHECKER:
                begin
                    v = ((i / w + i % w) % 2 == 0) ? '1 : '0;
                    r = v; g = ~v; b = v;
                end
                default:
                begin
                    r = pick_level(); g = pick_level(); b = pick_level();
                end
            endcase
            send_pixel(fs, r, g, b);
        end
    endtask

    // waiting out the edge that completes the last input lets the monitor book it before the queue is polled
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // width only, weights stay as they are
    task automatic program_width(input int width);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PADDED_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic program_regs(input int width, input int cw, input int ew);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PADDED_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_CENTER_WEIGHT;
        cfg_data  <= {PAD_W'($urandom), WEIGHT_W'(cw)};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_EDGE_WEIGHT;
        cfg_data  <= {PAD_W'($urandom), WEIGHT_W'(ew)};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        int          dir_w [7];
        int          dir_c [7];
        int          dir_e [7];
        pattern_t    dir_p [7];
        int          random_pixels;
        int          sel;
        int          width;
        int unsigned w_eff;
        int          n;
        bit          noisy;
        pattern_t    pat;

        dir_w = '{0, 1, 2, 3, 4, 5, 5};
        dir_c = '{127, -128, 127, -128, 0, 1, 0};
        dir_e = '{-128, 127, 127, -128, 0, 0, 1};
        dir_p = '{PAT_CHECKER, PAT_CHECKER, PAT_WHITE, PAT_WHITE,
                  PAT_RANDOM, PAT_RANDOM, PAT_BLACK};

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, no frame start on the very first pixel, part of a full-width row
        send_frame(MAX_WIDTH, 30, PAT_RANDOM, 1'b0, 0);
        // shrink mid-row under the reset weights: the row ends at once
        program_width(6);
        send_frame(6, 24, PAT_RANDOM, 1'b0, 0);

        // widths 0 to 5, some below the minimum, with weights at their extremes or at 0 and 1
        for (int i = 0; i < 7; i++)
        begin
            program_regs(dir_w[i], dir_c[i], dir_e[i]);
            w_eff = sb.eff_width();
            send_frame(w_eff, 4 * w_eff, dir_p[i], 1'b1, 0);
        end

        // oversized width, then shrink mid-frame so the row ends at once
        program_regs(2047, 9, -1);
        send_frame(MAX_WIDTH, 40, PAT_RANDOM, 1'b1, 0);
        program_regs(6, 9, -1);
        send_frame(6, 18, PAT_RANDOM, 1'b0, 0);

        // width grows mid-frame if the extra columns hold data from earlier frames; else a frame start is sent
        program_regs(4, 2, 0);
        send_frame(4, 8, PAT_CHECKER, 1'b1, 0);
        program_regs(7, 2, 0);
        send_frame(7, 21, PAT_RANDOM, !sb.cols_ready(7), 0);

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            if (random_pixels >= RANDOM_PIXELS * 3 / 4)
                idle_on = 1'b0;
            sel = $urandom_range(0, 19);
            if (sel == 0)
                width = $urandom_range(MAX_WIDTH + 1, 2047);
            else if (sel <= 2)
                width = $urandom_range(0, MIN_WIDTH - 1);
            else if (sel <= 4)
                width = $urandom_range(13, 40);
            else
                width = $urandom_range(MIN_WIDTH, 12);
            program_regs(width, pick_weight(1'b1), pick_weight(1'b0));
            w_eff = sb.eff_width();
            if (sel == 0)
                n = $urandom_range(4, 30);
            else
                n = w_eff * $urandom_range(3, 6);
            noisy = ($urandom_range(0, 9) == 0);
            if (noisy)
                n = $urandom_range(1, n);
            pat = ($urandom_range(0, 7) == 0) ? PAT_CHECKER : PAT_RANDOM;
            // carrying on without a frame start only over columns that hold real data
            send_frame(w_eff, n, pat,
                       !noisy || $urandom_range(0, 1) == 1 || !sb.cols_ready(w_eff),
                       noisy ? 4 : 0);
            random_pixels += n;
        end

        settle();
        $display("Covered %0d input pixels and %0d output checks over %0d register settings",
                 sb.taken, sb.matched + sb.errors, n_settings);
        $display("Widths below 3 to above 1024, extreme weights, mid-frame width changes; %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
